[hdl/pal_pkg.sv]
// Shared constants, codes and types for the positional array list.
package pal_pkg;

  // List geometry.
  localparam int unsigned Capacity = 8;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PosW     = 4;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatusW  = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = ((ValueW + PosW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ValueW + StatusW + CountW + 7) / 8) * 8;

  // Operation requested by a transaction.
  localparam logic [KindW-1:0] KindInsFront = 3'd0;
  localparam logic [KindW-1:0] KindInsEnd   = 3'd1;
  localparam logic [KindW-1:0] KindInsPos   = 3'd2;
  localparam logic [KindW-1:0] KindRemFront = 3'd3;
  localparam logic [KindW-1:0] KindRemEnd   = 3'd4;
  localparam logic [KindW-1:0] KindRemPos   = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusFull   = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty  = 2'd2;
  localparam logic [StatusW-1:0] StatusBadPos = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming transaction
    logic execute;  // apply the operation and load the result
  } cmd_t;

endpackage

[hdl/pal_ctrl.sv]
// Controller: sequences capture and execution and owns the result handshake.
module pal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pal_pkg::cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   res_free;

  // A new transaction is taken whenever the capture register is idle.
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Execution waits until the result register is free or being emptied.
  assign res_free = !out_valid_q || out_ready_i;

  assign cmd_o.capture = accept;
  assign cmd_o.execute = (state_q == StExec) && res_free;

  // Next state and result valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (res_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/pal_datapath.sv]
// Datapath: entry registers, count, operation decode and result register.
module pal_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pal_pkg::cmd_t                       cmd_i,
  input  logic        [pal_pkg::KindW-1:0]    kind_i,
  input  logic signed [pal_pkg::ValueW-1:0]   value_i,
  input  logic        [pal_pkg::PosW-1:0]     position_i,
  output logic signed [pal_pkg::ValueW-1:0]   removed_value_o,
  output logic        [pal_pkg::StatusW-1:0]  status_o,
  output logic        [pal_pkg::CountW-1:0]   entry_count_o
);

  // Captured transaction.
  logic        [pal_pkg::KindW-1:0]   kind_q;
  logic signed [pal_pkg::ValueW-1:0]  value_q;
  logic        [pal_pkg::PosW-1:0]    position_q;

  // List state.
  logic signed [pal_pkg::ValueW-1:0]  entries_q [pal_pkg::Capacity];
  logic signed [pal_pkg::ValueW-1:0]  entries_d [pal_pkg::Capacity];
  logic        [pal_pkg::CountW-1:0]  count_q, count_d;

  // Result register.
  logic signed [pal_pkg::ValueW-1:0]  removed_q, removed_d;
  logic        [pal_pkg::StatusW-1:0] status_q, status_d;
  logic        [pal_pkg::CountW-1:0]  res_count_q;

  // Decoded operation.
  logic                               full, empty, do_ins, do_rem;
  logic        [pal_pkg::PosW-1:0]    count_ext;
  logic        [pal_pkg::IdxW-1:0]    tgt;

  assign full      = (count_q == pal_pkg::CountW'(pal_pkg::Capacity));
  assign empty     = (count_q == '0);
  assign count_ext = pal_pkg::PosW'(count_q);

  // Validate the request and choose the target slot.
  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    tgt      = '0;
    status_d = pal_pkg::StatusOk;
    unique case (kind_q)
      pal_pkg::KindInsFront, pal_pkg::KindInsEnd, pal_pkg::KindInsPos: begin
        if (full) begin
          status_d = pal_pkg::StatusFull;
        end else if (kind_q == pal_pkg::KindInsFront) begin
          do_ins = 1'b1;
        end else if (kind_q == pal_pkg::KindInsEnd) begin
          do_ins = 1'b1;
          tgt    = count_q[pal_pkg::IdxW-1:0];
        end else if (position_q > count_ext) begin
          status_d = pal_pkg::StatusBadPos;
        end else begin
          do_ins = 1'b1;
          tgt    = position_q[pal_pkg::IdxW-1:0];
        end
      end
      pal_pkg::KindRemFront, pal_pkg::KindRemEnd, pal_pkg::KindRemPos: begin
        if (empty) begin
          status_d = pal_pkg::StatusEmpty;
        end else if (kind_q == pal_pkg::KindRemFront) begin
          do_rem = 1'b1;
        end else if (kind_q == pal_pkg::KindRemEnd) begin
          do_rem = 1'b1;
          tgt    = pal_pkg::IdxW'(count_q - 1'b1);
        end else if (position_q >= count_ext) begin
          status_d = pal_pkg::StatusBadPos;
        end else begin
          do_rem = 1'b1;
          tgt    = position_q[pal_pkg::IdxW-1:0];
        end
      end
      default: begin
        // Unknown operations leave the list alone and report success.
      end
    endcase
  end

  // Each slot independently holds, shifts or loads.
  always_comb begin
    for (int i = 0; i < pal_pkg::Capacity; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (pal_pkg::IdxW'(i) == tgt) begin
          entries_d[i] = value_q;
        end else if ((i > 0) && (pal_pkg::IdxW'(i) > tgt)) begin
          entries_d[i] = entries_q[pal_pkg::IdxW'(i - 1)];
        end
      end else if (do_rem) begin
        if ((i < pal_pkg::Capacity - 1) && (pal_pkg::IdxW'(i) >= tgt)) begin
          entries_d[i] = entries_q[pal_pkg::IdxW'(i + 1)];
        end
      end
    end
  end

  // Count update and removed entry.
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_rem) begin
      count_d   = count_q - 1'b1;
      removed_d = entries_q[tgt];
    end
  end

  // Control state: the entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Payload registers: transaction capture, entries and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= kind_i;
      value_q    <= value_i;
      position_q <= position_i;
    end
    if (cmd_i.execute) begin
      entries_q   <= entries_d;
      removed_q   <= removed_d;
      status_q    <= status_d;
      res_count_q <= count_d;
    end
  end

  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign entry_count_o   = res_count_q;

endmodule

[hdl/positional_array_list.sv]
// Top level of the positional array list: a bounded ordered list with shifting slots.
// Each transaction is captured, then executed into the result register; a waiting result
// holds execution, and one more transaction is captured behind it. No new transaction is
// taken until the previous one has executed (controller capture/execute sequence).
// Reset: asynchronous, active low; clears the entry count and the handshake state.
// Entry contents are not cleared and are only read below the count.
module positional_array_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // value [31:0], position [35:32], zero padding above
  input  logic [pal_pkg::InDataW-1:0]   s_axis_tdata,
  // kind [2:0]
  input  logic [pal_pkg::KindW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // removed_value [31:0], status [33:32], entry_count [37:34], zero padding above
  output logic [pal_pkg::OutDataW-1:0]  m_axis_tdata
);

  pal_pkg::cmd_t                        cmd;
  logic signed [pal_pkg::ValueW-1:0]    removed_value;
  logic        [pal_pkg::StatusW-1:0]   status;
  logic        [pal_pkg::CountW-1:0]    entry_count;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  pal_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (s_axis_tuser),
    .value_i         (s_axis_tdata[pal_pkg::ValueW-1:0]),
    .position_i      (s_axis_tdata[pal_pkg::ValueW +: pal_pkg::PosW]),
    .removed_value_o (removed_value),
    .status_o        (status),
    .entry_count_o   (entry_count)
  );

  // Pack the result fields.
  assign m_axis_tdata = pal_pkg::OutDataW'({entry_count, status, removed_value});

`ifndef NO_ASSERTIONS
  // A full report always comes with a full list.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == pal_pkg::StatusFull)
      |-> (entry_count == pal_pkg::CountW'(pal_pkg::Capacity)))
    else $error("full status with list not full");

  // An empty report always comes with an empty list.
  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == pal_pkg::StatusEmpty) |-> (entry_count == '0))
    else $error("empty status with entries held");

  // The count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (entry_count <= pal_pkg::CountW'(pal_pkg::Capacity)))
    else $error("entry count beyond capacity");

  // An accepted transaction blocks the next one while it executes.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted during execution");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the positional array list, driven over its stream ports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind codes that the block must treat as no operation.
  localparam logic [pal_pkg::KindW-1:0] KindSpareLo = 3'd6;
  localparam logic [pal_pkg::KindW-1:0] KindSpareHi = 3'd7;

  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned SettleCycles   = 8;

  // One expected result, field by field.
  typedef struct packed {
    logic [pal_pkg::ValueW-1:0]  removed_value;
    logic [pal_pkg::StatusW-1:0] status;
    logic [pal_pkg::CountW-1:0]  entry_count;
  } list_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // value [31:0], position [35:32], zero padding above
  logic [pal_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  // kind [2:0]
  logic [pal_pkg::KindW-1:0]    s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // removed_value [31:0], status [33:32], entry_count [37:34], zero padding above
  logic [pal_pkg::OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the list and the results it predicts.
  logic [pal_pkg::ValueW-1:0]   shadow_list [pal_pkg::Capacity];
  int unsigned                  shadow_count;
  list_result_t                 pending_results [$];

  // Run bookkeeping.
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned status_tally [4];
  int unsigned peak_count    = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;

  positional_array_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Apply one operation to the shadow list and return the result it should give.
  function automatic list_result_t predict_list_op(input logic [pal_pkg::KindW-1:0] kind,
                                                   input logic [pal_pkg::ValueW-1:0] value,
                                                   input logic [pal_pkg::PosW-1:0] pos);
    list_result_t res;
    int unsigned  slot;
    int unsigned  i;
    res.removed_value = '0;
    res.status        = pal_pkg::StatusOk;
    slot              = 0;
    if (kind == pal_pkg::KindInsFront || kind == pal_pkg::KindInsEnd ||
        kind == pal_pkg::KindInsPos) begin
      if (shadow_count >= pal_pkg::Capacity) begin
        res.status = pal_pkg::StatusFull;
      end else if (kind == pal_pkg::KindInsPos && pos > shadow_count) begin
        res.status = pal_pkg::StatusBadPos;
      end else begin
        if (kind == pal_pkg::KindInsEnd) slot = shadow_count;
        else if (kind == pal_pkg::KindInsPos) slot = pos;
        for (i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[slot] = value;
        shadow_count++;
      end
    end else if (kind == pal_pkg::KindRemFront || kind == pal_pkg::KindRemEnd ||
                 kind == pal_pkg::KindRemPos) begin
      if (shadow_count == 0) begin
        res.status = pal_pkg::StatusEmpty;
      end else if (kind == pal_pkg::KindRemPos && pos >= shadow_count) begin
        res.status = pal_pkg::StatusBadPos;
      end else begin
        if (kind == pal_pkg::KindRemEnd) slot = shadow_count - 1;
        else if (kind == pal_pkg::KindRemPos) slot = pos;
        res.removed_value = shadow_list[slot];
        shadow_count--;
        for (i = slot; i < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
      end
    end
    res.entry_count = pal_pkg::CountW'(shadow_count);
    if (shadow_count > peak_count) peak_count = shadow_count;
    return res;
  endfunction

  // Offer one transaction, optionally after an idle burst, and predict it once accepted.
  task automatic send_list_op(input logic [pal_pkg::KindW-1:0] kind,
                              input logic [pal_pkg::ValueW-1:0] value,
                              input logic [pal_pkg::PosW-1:0] pos);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pal_pkg::InDataW'({pos, value});
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_list_op(kind, value, pos));
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been returned.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Values lean towards the extremes now and then.
  function automatic logic [pal_pkg::ValueW-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position for the current fill, sometimes anything the field holds.
  function automatic logic [pal_pkg::PosW-1:0] random_position(input bit for_insert);
    if ($urandom_range(0, 7) == 0) return pal_pkg::PosW'($urandom_range(0, 15));
    if (for_insert) return pal_pkg::PosW'($urandom_range(0, shadow_count));
    if (shadow_count == 0) return '0;
    return pal_pkg::PosW'($urandom_range(0, shadow_count - 1));
  endfunction

  // Random operations; fill_pct sets how often an insert is chosen over a removal.
  task automatic run_random_ops(input int unsigned n, input int unsigned fill_pct);
    logic [pal_pkg::KindW-1:0] kind;
    int unsigned               r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        kind = ($urandom_range(0, 1) != 0) ? KindSpareHi : KindSpareLo;
      end else if (r < 5 + (fill_pct * 95) / 100) begin
        case ($urandom_range(0, 2))
          0:       kind = pal_pkg::KindInsFront;
          1:       kind = pal_pkg::KindInsEnd;
          default: kind = pal_pkg::KindInsPos;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = pal_pkg::KindRemFront;
          1:       kind = pal_pkg::KindRemEnd;
          default: kind = pal_pkg::KindRemPos;
        endcase
      end
      send_list_op(kind, random_value(), random_position(kind <= pal_pkg::KindInsPos));
    end
  endtask

  // Removals and unknown kinds on an empty list, and a positional insert past the end.
  task automatic test_empty_list();
    send_list_op(pal_pkg::KindRemFront, 32'h1234_5678, 4'd0);
    send_list_op(pal_pkg::KindRemEnd, 32'h0, 4'd0);
    send_list_op(pal_pkg::KindRemPos, 32'h0, 4'd0);
    send_list_op(KindSpareLo, 32'hDEAD_BEEF, 4'd15);
    send_list_op(KindSpareHi, 32'h0, 4'd0);
    send_list_op(pal_pkg::KindInsPos, 32'h5555_5555, 4'd1);
  endtask

  // Every insert kind, with an append through a position equal to the count.
  task automatic test_insert_ops();
    send_list_op(pal_pkg::KindInsPos, 32'h7FFF_FFFF, 4'd0);
    send_list_op(pal_pkg::KindInsFront, 32'h8000_0000, 4'd0);
    send_list_op(pal_pkg::KindInsEnd, 32'hFFFF_FFFF, 4'd9);
    send_list_op(pal_pkg::KindInsPos, 32'h0000_0000, 4'd3);
    send_list_op(pal_pkg::KindInsPos, 32'hAAAA_AAAA, 4'd15);
    send_list_op(pal_pkg::KindInsPos, 32'h0F0F_0F0F, 4'd2);
  endtask

  // Fill the list and try to insert beyond its capacity.
  task automatic test_full_list();
    send_list_op(pal_pkg::KindInsFront, 32'h0000_0001, 4'd0);
    send_list_op(pal_pkg::KindInsFront, 32'h0000_0002, 4'd0);
    send_list_op(pal_pkg::KindInsFront, 32'h0000_0003, 4'd0);
    send_list_op(pal_pkg::KindInsEnd, 32'h0000_0004, 4'd0);
    send_list_op(pal_pkg::KindInsPos, 32'h0000_0005, 4'd15);
    send_list_op(KindSpareHi, 32'h0000_0006, 4'd3);
  endtask

  // Every removal kind, with positions at and past the count.
  task automatic test_remove_ops();
    send_list_op(pal_pkg::KindRemPos, 32'h0, 4'd8);
    send_list_op(pal_pkg::KindRemPos, 32'h0, 4'd15);
    send_list_op(pal_pkg::KindRemPos, 32'h0, 4'd3);
    send_list_op(pal_pkg::KindRemEnd, 32'h0, 4'd0);
    send_list_op(pal_pkg::KindRemFront, 32'h0, 4'd0);
    send_list_op(pal_pkg::KindRemPos, 32'h0, 4'd0);
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while transactions keep coming.
  task automatic test_stall_pressure();
    holds_asked++;
    run_random_ops(30, 50);
    wait_results_drained();
  endtask

  // Bursts that push the fill up and down, with full drains between some of them.
  task automatic test_random_mix();
    int unsigned fill_pcts [5];
    int unsigned b;
    fill_pcts = '{80, 20, 50, 90, 10};
    for (b = 0; b < 26; b++) begin
      run_random_ops(50, fill_pcts[b % 5]);
      if (b % 5 == 4) wait_results_drained();
    end
    wait_results_drained();
  endtask

  // The closing stretch runs with no idling on either side.
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_ops(80, 75);
    run_random_ops(80, 30);
    run_random_ops(80, 60);
    wait_results_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : drive_result_ready
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare every returned transaction with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, actual %h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        status_tally[want.status]++;
        check_field("removed_value", want.removed_value, m_axis_tdata[31:0]);
        check_field("status", 32'(want.status), 32'(m_axis_tdata[33:32]));
        check_field("entry_count", 32'(want.entry_count), 32'(m_axis_tdata[37:34]));
      end
    end
  end

  initial begin : run_limit
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin : run_tests
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (shadow_list[i]) shadow_list[i] = '0;
    shadow_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_insert_ops();
    test_full_list();
    test_remove_ops();
    test_stall_pressure();
    test_random_mix();
    test_back_to_back();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t ns: results outstanding at the end, expected 0, actual %0d",
               $time, pending_results.size());
      mismatches++;
    end
    $display("Ran %0d list operations and checked %0d results; peak fill %0d of %0d.",
             items_sent, results_seen, peak_count, pal_pkg::Capacity);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, bad position %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
